// ===== rtl/pip_pkg.sv =====
`default_nettype none
package pip_pkg;

  localparam int MaxVertices = 64;
  localparam int AddrW = $clog2(MaxVertices);
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int CfgIdxW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VERTEX_COUNT = 4'd0,
    REG_OFFSET_X     = 4'd1,
    REG_OFFSET_Y     = 4'd2,
    REG_CENTER_X     = 4'd3,
    REG_CENTER_Y     = 4'd4,
    REG_ROTATE_EN    = 4'd5,
    REG_COS_ANGLE    = 4'd6,
    REG_SIN_ANGLE    = 4'd7
  } reg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [5:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } item_t;

  typedef struct packed {
    logic [6:0]         vertex_count;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic               rotate_en;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/point_in_polygon_test_top.sv =====
// Channel | Signals                                   | Accepted when
// input   | in_valid_i, in_ready_o, mode/index/x/y    | in_valid_i && in_ready_o
// result  | out_valid_o, out_ready_i, inside_res      | out_valid_o && out_ready_i
// config  | cfg_valid_i, cfg_ready_o, index, data     | cfg_valid_i (always ready)
// Vertex write: done from the engine's idle state once it reaches the head of the queue.
// Query: the closing vertex is read, translated, multiplied and rotated first; then each vertex
// is read, translated, multiplied, rotated, differenced, multiplied and compared, one at a time.
// A two-entry queue decouples input from the engine; the result register holds
// until taken. Reset clears control and configuration; vertex memory is not cleared.
`default_nettype none
module point_in_polygon_test_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                in_mode_i,
  input  wire  [5:0]         in_index_i,
  input  wire  signed [31:0] in_x_i,
  input  wire  signed [31:0] in_y_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic               out_inside_res_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [3:0]         cfg_index_i,
  input  wire  [31:0]        cfg_data_i
);

  pip_pkg::cfg_t  cfg_q;
  logic           q_valid, q_pop;
  pip_pkg::item_t q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertex_count <= '0;
      cfg_q.offset_x     <= '0;
      cfg_q.offset_y     <= '0;
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.rotate_en    <= 1'b0;
      cfg_q.cos_angle    <= 16'sd16384;
      cfg_q.sin_angle    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pip_pkg::REG_VERTEX_COUNT: cfg_q.vertex_count <= cfg_data_i[6:0];
        pip_pkg::REG_OFFSET_X:     cfg_q.offset_x     <= cfg_data_i;
        pip_pkg::REG_OFFSET_Y:     cfg_q.offset_y     <= cfg_data_i;
        pip_pkg::REG_CENTER_X:     cfg_q.center_x     <= cfg_data_i;
        pip_pkg::REG_CENTER_Y:     cfg_q.center_y     <= cfg_data_i;
        pip_pkg::REG_ROTATE_EN:    cfg_q.rotate_en    <= cfg_data_i[0];
        pip_pkg::REG_COS_ANGLE:    cfg_q.cos_angle    <= cfg_data_i[15:0];
        pip_pkg::REG_SIN_ANGLE:    cfg_q.sin_angle    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  pip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_mode_i  (in_mode_i),
    .in_index_i (in_index_i),
    .in_x_i     (in_x_i),
    .in_y_i     (in_y_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  pip_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (out_inside_res_o)
  );

endmodule
`default_nettype wire

// ===== rtl/pip_front.sv =====
`default_nettype none
module pip_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire                 in_mode_i,
  input  wire  [5:0]          in_index_i,
  input  wire  signed [31:0]  in_x_i,
  input  wire  signed [31:0]  in_y_i,
  output logic                q_valid_o,
  output pip_pkg::item_t      q_item_o,
  input  wire                 q_pop_i
);

  pip_pkg::item_t buf_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;
  pip_pkg::item_t item;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rd_ptr_q];

  always_comb begin
    item.op    = in_mode_i ? pip_pkg::OP_QUERY : pip_pkg::OP_WRITE;
    item.index = in_index_i;
    item.x     = in_x_i;
    item.y     = in_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (q_pop_i && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pip_engine.sv =====
`default_nettype none
module pip_engine (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  pip_pkg::cfg_t    cfg_i,
  input  wire              q_valid_i,
  input  pip_pkg::item_t   q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic             inside_res_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_READ  = 8'b00000010,
    S_XLATE = 8'b00000100,
    S_MUL   = 8'b00001000,
    S_ROT   = 8'b00010000,
    S_DIFF  = 8'b00100000,
    S_PROD  = 8'b01000000,
    S_CMP   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [63:0] mem [pip_pkg::MaxVertices];
  logic [63:0] rd_q;

  logic [pip_pkg::CntW-1:0]  n_q, step_q;
  logic [pip_pkg::CntW-1:0]  n_cfg;
  logic [pip_pkg::AddrW-1:0] rd_addr;
  logic                      inside_q;
  logic                      out_valid_q, res_q;
  logic signed [31:0]        px_q, py_q;
  logic signed [31:0]        tx_q, ty_q;
  logic signed [48:0]        pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [31:0]        cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic signed [31:0]        wx, wy;
  logic signed [32:0]        a_q, b_q, c_q, dy_q;
  logic                      straddle_q;
  logic signed [65:0]        lhs_q, rhs_q;
  logic signed [32:0]        dx_s, dy_s;
  logic                      left;
  logic                      start, wr_en;

  assign n_cfg = (cfg_i.vertex_count > pip_pkg::CntW'(pip_pkg::MaxVertices)) ?
                 pip_pkg::CntW'(pip_pkg::MaxVertices) : cfg_i.vertex_count[pip_pkg::CntW-1:0];

  assign rd_addr = (step_q == '0) ? pip_pkg::AddrW'(n_q - 1'b1)
                                  : pip_pkg::AddrW'(step_q - 1'b1);

  assign wr_en = (state_q == S_IDLE) && q_valid_i && (q_item_i.op == pip_pkg::OP_WRITE) &&
                 (int'(q_item_i.index) < pip_pkg::MaxVertices);
  assign start = (state_q == S_IDLE) && q_valid_i && (q_item_i.op == pip_pkg::OP_QUERY) &&
                 !out_valid_q;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i &&
                   ((q_item_i.op == pip_pkg::OP_WRITE) || !out_valid_q);

  assign dx_s = 33'(tx_q) - 33'(cfg_i.center_x);
  assign dy_s = 33'(ty_q) - 33'(cfg_i.center_y);

  always_comb begin
    logic signed [39:0] sx, sy;
    sx = 40'(cfg_i.center_x) + 40'(pxc_q >>> 14) - 40'(pys_q >>> 14);
    sy = 40'(cfg_i.center_y) + 40'(pxs_q >>> 14) + 40'(pyc_q >>> 14);
    if (cfg_i.rotate_en) begin
      wx = pip_pkg::sat32(sx);
      wy = pip_pkg::sat32(sy);
    end else begin
      wx = tx_q;
      wy = ty_q;
    end
  end

  assign left = (dy_q > 0) ? (lhs_q < rhs_q) : (rhs_q < lhs_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[q_item_i.index[pip_pkg::AddrW-1:0]] <= {q_item_i.x, q_item_i.y};
    end
    if (state_q == S_READ) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      px_q <= q_item_i.x;
      py_q <= q_item_i.y;
    end
    if (state_q == S_XLATE) begin
      tx_q <= pip_pkg::sat32(40'($signed(rd_q[63:32])) + 40'(cfg_i.offset_x));
      ty_q <= pip_pkg::sat32(40'($signed(rd_q[31:0])) + 40'(cfg_i.offset_y));
    end
    if (state_q == S_MUL) begin
      pxc_q <= 49'(dx_s) * 49'(cfg_i.cos_angle);
      pys_q <= 49'(dy_s) * 49'(cfg_i.sin_angle);
      pxs_q <= 49'(dx_s) * 49'(cfg_i.sin_angle);
      pyc_q <= 49'(dy_s) * 49'(cfg_i.cos_angle);
    end
    if (state_q == S_ROT) begin
      cur_x_q <= wx;
      cur_y_q <= wy;
      if (step_q == '0) begin
        prev_x_q <= wx;
        prev_y_q <= wy;
      end
    end
    if (state_q == S_DIFF) begin
      straddle_q <= (cur_y_q > py_q) != (prev_y_q > py_q);
      a_q  <= 33'(px_q) - 33'(cur_x_q);
      dy_q <= 33'(prev_y_q) - 33'(cur_y_q);
      b_q  <= 33'(prev_x_q) - 33'(cur_x_q);
      c_q  <= 33'(py_q) - 33'(cur_y_q);
    end
    if (state_q == S_PROD) begin
      lhs_q <= 66'(a_q) * 66'(dy_q);
      rhs_q <= 66'(b_q) * 66'(c_q);
    end
    if (state_q == S_CMP) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start && n_cfg != '0) state_d = S_READ;
      S_READ:  state_d = S_XLATE;
      S_XLATE: state_d = S_MUL;
      S_MUL:   state_d = S_ROT;
      S_ROT:   state_d = (step_q == '0) ? S_READ : S_DIFF;
      S_DIFF:  state_d = S_PROD;
      S_PROD:  state_d = S_CMP;
      S_CMP:   state_d = (step_q == n_q) ? S_IDLE : S_READ;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      step_q      <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (start) begin
        n_q      <= n_cfg;
        step_q   <= '0;
        inside_q <= 1'b0;
        if (n_cfg == '0) begin
          out_valid_q <= 1'b1;
          res_q       <= 1'b0;
        end
      end
      if (state_q == S_ROT && step_q == '0) step_q <= step_q + 1'b1;
      if (state_q == S_CMP) begin
        inside_q <= inside_q ^ (straddle_q && left);
        if (step_q == n_q) begin
          out_valid_q <= 1'b1;
          res_q       <= inside_q ^ (straddle_q && left);
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = res_q;

endmodule
`default_nettype wire

// ===== rtl/pip_checker.sv =====
`default_nettype none
module pip_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_ready_o,
  input wire out_valid_o,
  input wire out_ready_i,
  input wire out_inside_res_o,
  input wire cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_inside_res_o))
    else $error("result dropped or changed while stalled");

  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o}))
    else $error("handshake output unknown");

  a_res_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_inside_res_o))
    else $error("result unknown while valid");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_inside_res_o (out_inside_res_o),
  .cfg_ready_o      (cfg_ready_o)
);
`default_nettype wire

// ===== test/point_in_polygon_test_top_chk.sv =====
`timescale 1ns / 100ps
`default_nettype none
module point_in_polygon_test_top_chk (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_o,
  input  wire         in_mode_i,
  input  wire  [5:0]  in_index_i,
  input  wire  [31:0] in_x_i,
  input  wire  [31:0] in_y_i,
  input  wire         out_valid_o,
  input  wire         out_ready_i,
  input  wire         out_inside_res_o,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_o,
  input  wire  [3:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [31:0]   vert_x [pip_pkg::MaxVertices];
  logic [31:0]   vert_y [pip_pkg::MaxVertices];
  pip_pkg::cfg_t cfg;
  bit            inside_q [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor14(longint v);
    return v >>> 14;
  endfunction

  function automatic void place_vertex(int k, output longint wx, output longint wy);
    longint tx, ty, dx, dy, c, s, cx, cy;
    tx = clamp32(longint'($signed(vert_x[k])) + longint'(cfg.offset_x));
    ty = clamp32(longint'($signed(vert_y[k])) + longint'(cfg.offset_y));
    if (cfg.rotate_en) begin
      cx = cfg.center_x;
      cy = cfg.center_y;
      c = cfg.cos_angle;
      s = cfg.sin_angle;
      dx = tx - cx;
      dy = ty - cy;
      tx = clamp32(cx + floor14(dx * c) - floor14(dy * s));
      ty = clamp32(cy + floor14(dx * s) + floor14(dy * c));
    end
    wx = tx;
    wy = ty;
  endfunction

  function automatic bit crossing_parity(longint px, longint py);
    int n;
    bit ins;
    longint xi, yi, xj, yj, dy;
    logic signed [127:0] lhs, rhs;
    n = (cfg.vertex_count > pip_pkg::MaxVertices) ? pip_pkg::MaxVertices : cfg.vertex_count;
    ins = 0;
    if (n == 0) return 0;
    place_vertex(n - 1, xj, yj);
    for (int i = 0; i < n; i++) begin
      place_vertex(i, xi, yi);
      if ((yi > py) != (yj > py)) begin
        dy = yj - yi;
        lhs = 128'(px - xi) * 128'(dy);
        rhs = 128'(xj - xi) * 128'(py - yi);
        if (dy > 0 ? (lhs < rhs) : (rhs < lhs)) ins = !ins;
      end
      xj = xi;
      yj = yi;
    end
    return ins;
  endfunction

  assign pending_o = inside_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.vertex_count <= '0;
      cfg.offset_x <= '0;
      cfg.offset_y <= '0;
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      cfg.rotate_en <= 1'b0;
      cfg.cos_angle <= 16'sd16384;
      cfg.sin_angle <= '0;
      fail_count_o <= 0;
      inside_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (pip_pkg::reg_idx_e'(cfg_index_i))
          pip_pkg::REG_VERTEX_COUNT: cfg.vertex_count <= cfg_data_i[6:0];
          pip_pkg::REG_OFFSET_X:     cfg.offset_x <= cfg_data_i;
          pip_pkg::REG_OFFSET_Y:     cfg.offset_y <= cfg_data_i;
          pip_pkg::REG_CENTER_X:     cfg.center_x <= cfg_data_i;
          pip_pkg::REG_CENTER_Y:     cfg.center_y <= cfg_data_i;
          pip_pkg::REG_ROTATE_EN:    cfg.rotate_en <= cfg_data_i[0];
          pip_pkg::REG_COS_ANGLE:    cfg.cos_angle <= cfg_data_i[15:0];
          pip_pkg::REG_SIN_ANGLE:    cfg.sin_angle <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        if (pip_pkg::op_e'(in_mode_i) == pip_pkg::OP_WRITE) begin
          vert_x[in_index_i] <= in_x_i;
          vert_y[in_index_i] <= in_y_i;
        end else begin
          inside_q.push_back(crossing_parity($signed(in_x_i), $signed(in_y_i)));
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (inside_q.size() == 0) begin
          $error("inside_res: unexpected item, actual %0b", out_inside_res_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (out_inside_res_o !== inside_q[0]) begin
            $error("inside_res: expected %0b, actual %0b", inside_q[0], out_inside_res_o);
            fail_count_o <= fail_count_o + 1;
          end
          void'(inside_q.pop_front());
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/point_in_polygon_test_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module point_in_polygon_test_top_tb;

  localparam int WatchLimit = 20000;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_mode;
  logic [5:0]  in_index;
  logic [31:0] in_x, in_y;
  logic        out_valid, out_ready, out_inside;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending, idle_cycles;
  bit          quiet_in, quiet_out;
  int          hull_n;

  point_in_polygon_test_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_mode_i(in_mode),
    .in_index_i(in_index), .in_x_i(in_x), .in_y_i(in_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_inside_res_o(out_inside),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  point_in_polygon_test_top_chk chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_mode_i(in_mode),
    .in_index_i(in_index), .in_x_i(in_x), .in_y_i(in_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_inside_res_o(out_inside),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(pip_pkg::op_e op, logic [5:0] idx, logic [31:0] x, logic [31:0] y);
    cfg_valid <= 1'b0;
    while (!quiet_in && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= op;
    in_index <= idx;
    in_x <= x;
    in_y <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(pip_pkg::reg_idx_e idx, logic [31:0] data);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (7 * pip_pkg::MaxVertices + 40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $signed($urandom_range(2 * 65536 * 200)) - 65536 * 200;
    endcase
  endfunction

  task automatic load_polygon(int n, bit wild);
    int r;
    real a;
    for (int k = 0; k < n; k++) begin
      a = 6.2831853 * k / n;
      r = 65536 * (20 + $urandom_range(60));
      if (wild && $urandom_range(3) == 0) begin
        send_item(pip_pkg::OP_WRITE, 6'(k), rand_coord(), rand_coord());
      end else begin
        send_item(pip_pkg::OP_WRITE, 6'(k), $rtoi(r * $cos(a)), $rtoi(r * $sin(a)));
      end
    end
  endtask

  task automatic query_point();
    if ($urandom_range(4) == 0) begin
      send_item(pip_pkg::OP_QUERY, 6'($urandom()), rand_coord(), rand_coord());
    end else begin
      send_item(pip_pkg::OP_QUERY, 6'($urandom()),
                $signed($urandom_range(65536 * 200)) - 65536 * 100,
                $signed($urandom_range(65536 * 200)) - 65536 * 100);
    end
  endtask

  initial begin
    int n, reps;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_index = '0;
    in_x = '0;
    in_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(pip_pkg::OP_QUERY, 6'h3f, 32'h7fffffff, 32'h80000000);
    send_item(pip_pkg::OP_WRITE, 6'd0, 32'h80000000, 32'h80000000);
    send_item(pip_pkg::OP_WRITE, 6'd1, 32'h7fffffff, 32'h80000000);
    send_item(pip_pkg::OP_WRITE, 6'd2, 32'h00000000, 32'h7fffffff);
    send_item(pip_pkg::OP_WRITE, 6'd63, 32'hffffffff, 32'h00010000);
    drain();
    write_reg(pip_pkg::REG_VERTEX_COUNT, 32'd1);
    send_item(pip_pkg::OP_QUERY, '0, 32'h0, 32'h0);
    drain();
    write_reg(pip_pkg::REG_VERTEX_COUNT, 32'd3);
    send_item(pip_pkg::OP_QUERY, '0, 32'h0, 32'h0);
    send_item(pip_pkg::OP_QUERY, '0, 32'h80000000, 32'h7fffffff);
    send_item(pip_pkg::OP_QUERY, '0, 32'h7fffffff, 32'h80000000);
    send_item(pip_pkg::OP_QUERY, '0, 32'h80000000, 32'h80000000);
    drain();
    write_reg(pip_pkg::REG_OFFSET_X, 32'h7fffffff);
    write_reg(pip_pkg::REG_OFFSET_Y, 32'h80000000);
    send_item(pip_pkg::OP_QUERY, '0, 32'h7fffffff, 32'h0);
    drain();
    write_reg(pip_pkg::REG_ROTATE_EN, 32'd1);
    write_reg(pip_pkg::REG_CENTER_X, 32'h80000000);
    write_reg(pip_pkg::REG_CENTER_Y, 32'h7fffffff);
    write_reg(pip_pkg::REG_COS_ANGLE, 32'h0000c000);
    write_reg(pip_pkg::REG_SIN_ANGLE, 32'h00004000);
    send_item(pip_pkg::OP_QUERY, '0, 32'h0, 32'h0);
    send_item(pip_pkg::OP_QUERY, '0, 32'h12345678, 32'h87654321);
    drain();
    for (int k = 3; k < pip_pkg::MaxVertices; k++) begin
      if (k != 63) send_item(pip_pkg::OP_WRITE, 6'(k), rand_coord(), rand_coord());
    end
    drain();
    write_reg(pip_pkg::REG_VERTEX_COUNT, 32'h7f);
    write_reg(pip_pkg::REG_ROTATE_EN, 32'd0);
    write_reg(pip_pkg::REG_OFFSET_X, 32'h0);
    write_reg(pip_pkg::REG_OFFSET_Y, 32'h0);
    send_item(pip_pkg::OP_QUERY, '0, 32'h0, 32'h0);
    send_item(pip_pkg::OP_QUERY, '0, 32'h00100000, 32'hfff00000);

    for (int phase = 0; phase < 16; phase++) begin
      drain();
      quiet_in = (phase == 5);
      quiet_out = (phase == 5);
      case (phase % 4)
        0: n = $urandom_range(3, 8);
        1: n = $urandom_range(3, 16);
        2: n = (phase == 14) ? pip_pkg::MaxVertices : $urandom_range(0, 5);
        default: n = $urandom_range(3, 12);
      endcase
      write_reg(pip_pkg::REG_VERTEX_COUNT, n);
      write_reg(pip_pkg::REG_ROTATE_EN, phase % 2);
      write_reg(pip_pkg::REG_OFFSET_X,
                phase == 7 ? 32'h7fff0000 : $signed($urandom_range(65536 * 40)) - 65536 * 20);
      write_reg(pip_pkg::REG_OFFSET_Y,
                phase == 7 ? 32'h80010000 : $signed($urandom_range(65536 * 40)) - 65536 * 20);
      write_reg(pip_pkg::REG_CENTER_X, $signed($urandom_range(65536 * 40)) - 65536 * 20);
      write_reg(pip_pkg::REG_CENTER_Y, $signed($urandom_range(65536 * 40)) - 65536 * 20);
      case (phase % 3)
        0: begin
          write_reg(pip_pkg::REG_COS_ANGLE, 32'(16'sd16384));
          write_reg(pip_pkg::REG_SIN_ANGLE, 32'(-16'sd16384));
        end
        1: begin
          write_reg(pip_pkg::REG_COS_ANGLE, 32'(-16'sd16384));
          write_reg(pip_pkg::REG_SIN_ANGLE, 32'(16'sd16384));
        end
        default: begin
          write_reg(pip_pkg::REG_COS_ANGLE, $urandom_range(32768) - 16384);
          write_reg(pip_pkg::REG_SIN_ANGLE, $urandom_range(32768) - 16384);
        end
      endcase
      hull_n = (n > 3) ? n : 3;
      load_polygon(hull_n, phase % 4 == 3);
      reps = (n > 16) ? 10 : 40;
      for (int q = 0; q < reps; q++) begin
        if ($urandom_range(15) == 0) begin
          send_item(pip_pkg::OP_WRITE, 6'($urandom_range(hull_n - 1)), rand_coord(),
                    rand_coord());
        end else begin
          query_point();
        end
      end
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
